// ----- src/brf_pkg.sv -----
// types and constants for the byte ring fifo
// used by the channel interfaces, the controller, the datapath and the top level
package brf_pkg;

  localparam int BYTE_W  = 8;
  localparam int OP_W    = 3;
  localparam int LEN_W   = 7;
  localparam int CAP_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register word index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_PEEK    = 3'd1,
    OP_READ    = 3'd2,
    OP_DISCARD = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch the incoming word
    logic exec;   // execute a single-result command
    logic start;  // begin a peek or read sequence
    logic emit;   // send one stored byte
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic multi;
    logic last_byte;
  } status_t;

endpackage

// ----- src/brf_in_if.sv -----
// request channel of the byte ring fifo
// depends on brf_pkg for field widths
interface brf_in_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::OP_W-1:0]    op;
  logic [brf_pkg::BYTE_W-1:0]  write_byte;
  logic [brf_pkg::LEN_W-1:0]   length;
  logic                        first;

  modport source (output valid, op, write_byte, length, first, input ready);
  modport sink (input valid, op, write_byte, length, first, output ready);
endinterface

// ----- src/brf_out_if.sv -----
// response channel of the byte ring fifo
// depends on brf_pkg for field widths
interface brf_out_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::BYTE_W-1:0]  read_byte;
  logic                        status;
  logic [brf_pkg::LEN_W-1:0]   done_count;
  logic [brf_pkg::CAP_W-1:0]   fill_level;
  logic                        has_byte;
  logic                        last;

  modport source (output valid, read_byte, status, done_count, fill_level, has_byte, last,
                  input ready);
  modport sink (input valid, read_byte, status, done_count, fill_level, has_byte, last,
                output ready);
endinterface

// ----- src/brf_ctrl.sv -----
// controller of the byte ring fifo: command slot and sequencing state machine
// depends on brf_pkg for cmd_t, status_t and state_t
module brf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  brf_pkg::status_t stat,
  output brf_pkg::cmd_t    cmd
);

  brf_pkg::state_t state, state_next;
  logic cmd_valid, cmd_valid_next;
  logic consumed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brf_pkg::ST_IDLE;
      cmd_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmd_valid <= cmd_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    consumed   = 1'b0;
    unique case (state)
      brf_pkg::ST_IDLE: begin
        if (cmd_valid && stat.out_free) begin
          if (stat.multi) begin
            cmd.start  = 1'b1;
            state_next = brf_pkg::ST_RUN;
          end else begin
            cmd.exec = 1'b1;
            consumed = 1'b1;
          end
        end
      end
      brf_pkg::ST_RUN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_byte) begin
            consumed   = 1'b1;
            state_next = brf_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = brf_pkg::ST_IDLE;
    endcase
    // the slot refills in the cycle its word is retired
    req_ready      = !cmd_valid || consumed;
    cmd.load       = req_valid && req_ready;
    cmd_valid_next = cmd.load ? 1'b1 : (consumed ? 1'b0 : cmd_valid);
  end

endmodule

// ----- src/brf_dp.sv -----
// datapath of the byte ring fifo: command register, byte store, pointers,
// fill count, burst tracking and output register; depends on brf_pkg, brf_out_if
module brf_dp #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  brf_pkg::cmd_t                cmd,
  output brf_pkg::status_t             stat,
  input  logic [brf_pkg::CAP_W-1:0]    eff_cap,
  input  logic                         cfg_clear,
  input  logic [brf_pkg::OP_W-1:0]     op,
  input  logic [brf_pkg::BYTE_W-1:0]   write_byte,
  input  logic [brf_pkg::LEN_W-1:0]    length,
  input  logic                         first,
  brf_out_if.source                    rsp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = brf_pkg::LEN_W;
  localparam int CW = brf_pkg::CAP_W;
  localparam int XW = ((PW > CW) ? PW : CW) + 1;

  // latched command word
  logic [brf_pkg::OP_W-1:0]   c_op;
  logic [brf_pkg::BYTE_W-1:0] c_wb;
  logic [LW-1:0]              c_len;
  logic                       c_first;

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [brf_pkg::BYTE_W-1:0] rdata;

  logic [PW-1:0] wp, rp, addr;
  logic [PW-1:0] wp_next, rp_next, rd_addr;
  logic [CW-1:0] fill, fill_next;
  logic          brej, brej_next;
  logic [LW-1:0] bleft, bleft_next;
  logic [LW-1:0] cnt, n_reg;
  logic          is_read;
  logic          we;

  logic [LW-1:0] lenc, nclamp;
  logic          take, st;

  logic                       ovalid;
  logic [brf_pkg::BYTE_W-1:0] o_rb, o_rb_next;
  logic                       o_st, o_st_next;
  logic [LW-1:0]              o_dc, o_dc_next;
  logic [CW-1:0]              o_fill;
  logic                       o_hb, o_hb_next;
  logic                       o_last, o_last_next;

  logic [XW-1:0] ptr_diff;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] k,
                                        input logic [CW-1:0] c);
    logic [XW-1:0] s;
    s = XW'(p) + XW'(k);
    if (s >= XW'(c)) s = s - XW'(c);
    return PW'(s);
  endfunction

  assign lenc   = (c_len > LW'(MAX_BURST)) ? LW'(MAX_BURST) : c_len;
  assign nclamp = (CW'(lenc) < fill) ? lenc : fill[LW-1:0];

  assign stat.out_free  = !ovalid || rsp.ready;
  assign stat.multi     = ((c_op == brf_pkg::OP_PEEK) || (c_op == brf_pkg::OP_READ))
                          && (nclamp != '0);
  assign stat.last_byte = (cnt + LW'(1)) == n_reg;

  always_comb begin
    wp_next     = wp;
    rp_next     = rp;
    fill_next   = fill;
    brej_next   = brej;
    bleft_next  = bleft;
    we          = 1'b0;
    take        = 1'b0;
    st          = 1'b0;
    o_rb_next   = '0;
    o_st_next   = 1'b0;
    o_dc_next   = '0;
    o_hb_next   = 1'b0;
    o_last_next = 1'b1;
    if (cmd.exec) begin
      unique case (c_op)
        brf_pkg::OP_PUSH: begin
          if (c_first) begin
            if (lenc == '0) begin
              brej_next  = 1'b0;
              bleft_next = '0;
            end else if ((CW + 1)'(fill) + (CW + 1)'(lenc) > (CW + 1)'(eff_cap)) begin
              // whole burst will not fit: drop it all
              brej_next  = 1'b1;
              bleft_next = lenc - LW'(1);
              st         = 1'b1;
            end else begin
              brej_next  = 1'b0;
              bleft_next = lenc - LW'(1);
              take       = 1'b1;
            end
          end else if (bleft != '0) begin
            bleft_next = bleft - LW'(1);
            if (brej) st = 1'b1;
            else take = 1'b1;
          end
          if (take) begin
            if (fill >= eff_cap) begin
              st = 1'b1;
            end else begin
              we        = 1'b1;
              wp_next   = adv(wp, LW'(1), eff_cap);
              fill_next = fill + CW'(1);
              o_dc_next = LW'(1);
            end
          end
          o_st_next = st;
        end
        brf_pkg::OP_DISCARD: begin
          rp_next   = adv(rp, nclamp, eff_cap);
          fill_next = fill - CW'(nclamp);
          o_dc_next = nclamp;
        end
        brf_pkg::OP_CLEAR: begin
          wp_next    = '0;
          rp_next    = '0;
          fill_next  = '0;
          brej_next  = 1'b0;
          bleft_next = '0;
        end
        // empty peek or read, or an unknown code: plain result
        default: ;
      endcase
    end
    if (cmd.emit) begin
      o_rb_next   = rdata;
      o_hb_next   = 1'b1;
      o_dc_next   = n_reg;
      o_last_next = stat.last_byte;
      if (is_read) begin
        rp_next   = adv(rp, LW'(1), eff_cap);
        fill_next = fill - CW'(1);
      end
    end
    if (cfg_clear) begin
      wp_next    = '0;
      rp_next    = '0;
      fill_next  = '0;
      brej_next  = 1'b0;
      bleft_next = '0;
    end
  end

  // read one slot ahead so a byte can leave every cycle while the output is free
  always_comb begin
    priority if (cmd.start) rd_addr = rp;
    else if (cmd.emit) rd_addr = adv(addr, LW'(1), eff_cap);
    else rd_addr = addr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wp] <= c_wb;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      fill   <= '0;
      brej   <= 1'b0;
      bleft  <= '0;
      ovalid <= 1'b0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      fill  <= fill_next;
      brej  <= brej_next;
      bleft <= bleft_next;
      if (cmd.exec || cmd.emit) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr <= rd_addr;
    if (cmd.load) begin
      c_op    <= op;
      c_wb    <= write_byte;
      c_len   <= length;
      c_first <= first;
    end
    if (cmd.start) begin
      cnt     <= '0;
      n_reg   <= nclamp;
      is_read <= (c_op == brf_pkg::OP_READ);
    end else if (cmd.emit) begin
      cnt <= cnt + LW'(1);
    end
    if (cmd.exec || cmd.emit) begin
      o_rb   <= o_rb_next;
      o_st   <= o_st_next;
      o_dc   <= o_dc_next;
      o_fill <= fill_next;
      o_hb   <= o_hb_next;
      o_last <= o_last_next;
    end
  end

  assign rsp.valid      = ovalid;
  assign rsp.read_byte  = o_rb;
  assign rsp.status     = o_st;
  assign rsp.done_count = o_dc;
  assign rsp.fill_level = o_fill;
  assign rsp.has_byte   = o_hb;
  assign rsp.last       = o_last;

  // occupied span between the pointers, modulo capacity
  assign ptr_diff = (wp >= rp) ? (XW'(wp) - XW'(rp)) : (XW'(wp) + XW'(eff_cap) - XW'(rp));

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= eff_cap)
    else $error("fill count above capacity");

  a_ptr_span: assert property (@(posedge clk) disable iff (rst)
    (ptr_diff == XW'(fill)) || ((ptr_diff == '0) && (fill == eff_cap)))
    else $error("pointers disagree with fill count");

  a_emit_range: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> cnt < n_reg)
    else $error("byte emitted past the clamped count");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (c_op == brf_pkg::OP_CLEAR)) |=> (fill == '0) && (bleft == '0))
    else $error("clear left bytes behind");

endmodule

// ----- src/byte_ring_fifo_peek_discard.sv -----
// byte ring fifo with burst push, peek, read, discard and clear
// a word is latched in the command register at acceptance; a single-result word then
// goes to the output register, a peek/read first fetches its first byte from the store;
// with the output free, push, discard, clear and empty peek/read sustain one word per cycle
// peek/read of n bytes: a fetch from the store, then a byte per cycle with the output free
// reset (rst, synchronous) empties the fifo and sets capacity to 1024; no store clearing pass
module byte_ring_fifo_peek_discard #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brf_pkg::PADDR_W-1:0]   paddr,
  input  logic [brf_pkg::PDATA_W-1:0]   pwdata,
  output logic [brf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  brf_in_if.sink                        req,
  brf_out_if.source                     rsp
);

  localparam int CW = brf_pkg::CAP_W;
  localparam logic [CW-1:0] CAP_RESET = CW'(1024);
  localparam logic [CW-1:0] EFF_RESET = CW'((DEPTH < 1024) ? DEPTH : 1024);

  logic [CW-1:0] cap, eff_cap, wcap, weff;
  logic          cfg_clear;

  brf_pkg::cmd_t    cmd;
  brf_pkg::status_t stat;

  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && pready && (paddr[2] == brf_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == brf_pkg::REG_CAPACITY) ?
                     brf_pkg::PDATA_W'(cap) : '0;

  // zero acts as one slot, anything above the store acts as the full store
  assign wcap = pwdata[CW-1:0];
  always_comb begin
    priority if (wcap == '0) weff = CW'(1);
    else if (32'(wcap) > DEPTH) weff = CW'(DEPTH);
    else weff = wcap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CAP_RESET;
      eff_cap <= EFF_RESET;
    end else if (cfg_clear) begin
      cap     <= wcap;
      eff_cap <= weff;
    end
  end

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brf_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .eff_cap    (eff_cap),
    .cfg_clear  (cfg_clear),
    .op         (req.op),
    .write_byte (req.write_byte),
    .length     (req.length),
    .first      (req.first),
    .rsp        (rsp)
  );

endmodule
